FILE: hdl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Shared sizes, operation codes and status codes of the sorted set engine.
// ----------------------------------------------------------------------------
package sse_pkg;

    // Store geometry
    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int FUNC_W   = 4;
    localparam int IKEY_W   = 32;
    localparam int STATUS_W = 2;
    localparam int RKEY_W   = 32;
    localparam int COUNT_W  = 5;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    // Operation codes
    localparam t_func FN_INSERT = 4'd0;
    localparam t_func FN_REMOVE = 4'd1;
    localparam t_func FN_EXISTS = 4'd2;
    localparam t_func FN_MIN    = 4'd3;
    localparam t_func FN_MAX    = 4'd4;
    localparam t_func FN_RMMIN  = 4'd5;
    localparam t_func FN_RMMAX  = 4'd6;
    localparam t_func FN_PRED   = 4'd7;
    localparam t_func FN_SUCC   = 4'd8;
    localparam t_func FN_RMPRED = 4'd9;
    localparam t_func FN_RMSUCC = 4'd10;
    localparam t_func FN_CLEAR  = 4'd11;

    // Status codes
    localparam t_status STS_OK    = 2'd0;
    localparam t_status STS_MISS  = 2'd1;
    localparam t_status STS_EMPTY = 2'd2;
    localparam t_status STS_FULL  = 2'd3;

endpackage

FILE: hdl/sorted_set_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_set_engine_core
// Ordered set of distinct keys held ascending in a single-port memory, with
// insert, remove, lookup, extreme and neighbour operations.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                   | Handshake
//  ---------+-------------------------------------------+----------------------
//  request  | i_func, i_key                             | start high, busy low
//  result   | o_status, o_found, o_result_key, o_count  | o_valid, one cycle
//
// A transaction scans from entry 0, reading and then comparing each entry, then
// an insert or a removal moves the later entries one place, a read and a write
// for each. Clear, an undefined code and an empty set skip the scan.
// Reset empties the set at once; memory contents are left as they are.
// The receiver cannot stall: o_valid is high for one cycle per transaction.
module sorted_set_engine_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [sse_pkg::FUNC_W-1:0]   i_func,
    input  logic [sse_pkg::IKEY_W-1:0]   i_key,
    output logic                         o_valid,
    output logic [sse_pkg::STATUS_W-1:0] o_status,
    output logic                         o_found,
    output logic [sse_pkg::RKEY_W-1:0]   o_result_key,
    output logic [sse_pkg::COUNT_W-1:0]  o_count
);
    import sse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RESOLVE,
        S_SHU_RD,
        S_SHU_WR,
        S_INS_WR,
        S_DR_RD,
        S_DR_WR,
        S_FIN
    } t_state;

    t_state              r_state;
    t_func               r_func;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_pos;
    logic [KEY_BITS-1:0] r_cur;
    logic [KEY_BITS-1:0] r_prev;
    t_status             r_status;
    logic                r_found;
    logic [KEY_BITS-1:0] r_rk;

    logic [KEY_BITS-1:0] r_mem [CAPACITY];
    logic [KEY_BITS-1:0] r_rd_data;

    logic                mem_we;
    logic [CNT_W-1:0]    mem_addr;
    logic [KEY_BITS-1:0] mem_wdata;

    logic                needs_items;
    logic                known_func;
    logic                scan_stop;
    logic                in_range;
    logic                hit;
    logic [CNT_W-1:0]    drop_q;
    logic                drop_short;

    assign busy = (r_state != S_IDLE);

    // Memory port control follows the sequencer state.
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_idx;
        mem_wdata = r_rd_data;
        case (r_state)
            S_SHU_RD: begin
                mem_addr = CNT_W'(r_idx - 1'b1);
            end
            S_SHU_WR: begin
                mem_we = 1'b1;
            end
            S_DR_RD: begin
                mem_addr = CNT_W'(r_idx + 1'b1);
            end
            S_DR_WR: begin
                mem_we = 1'b1;
            end
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_addr  = r_pos;
                mem_wdata = r_key;
            end
            default: begin
                mem_addr = r_idx;
            end
        endcase
    end

    // Single-port key store with a registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr[IDX_W-1:0]] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_addr[IDX_W-1:0]];
    end

    // Request classification at acceptance.
    assign known_func  = (i_func <= FN_CLEAR);
    assign needs_items = known_func && (i_func != FN_INSERT) &&
                         (i_func != FN_EXISTS) && (i_func != FN_CLEAR);

    // Scan stop rule: minimum stops at once, maximum runs to the end,
    // successor looks for a strictly greater key, the rest for the first
    // key not below the request key.
    always_comb begin
        case (r_func)
            FN_MIN, FN_RMMIN: scan_stop = 1'b1;
            FN_MAX, FN_RMMAX: scan_stop = 1'b0;
            FN_SUCC, FN_RMSUCC: scan_stop = (r_rd_data > r_key);
            default: scan_stop = (r_rd_data >= r_key);
        endcase
    end

    assign in_range = (r_pos != r_count);
    assign hit      = in_range && (r_cur == r_key);

    // Entry to drop: the one just before the scan position for the
    // predecessor and maximum forms, else the one at it.
    assign drop_q = ((r_func == FN_RMPRED) || (r_func == FN_RMMAX)) ?
                    CNT_W'(r_pos - 1'b1) : r_pos;
    assign drop_short = (CNT_W'(drop_q + 1'b1) >= r_count);

    // Sequencer, working registers and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func   <= i_func;
                        r_key    <= KEY_BITS'(i_key);
                        r_status <= STS_OK;
                        r_found  <= 1'b0;
                        r_rk     <= '0;
                        r_idx    <= '0;
                        r_pos    <= '0;
                        if (!known_func) begin
                            r_status <= STS_MISS;
                            r_state  <= S_FIN;
                        end else if (i_func == FN_CLEAR) begin
                            r_count <= '0;
                            r_found <= 1'b1;
                            r_state <= S_FIN;
                        end else if (needs_items && (r_count == '0)) begin
                            r_status <= STS_EMPTY;
                            r_state  <= S_FIN;
                        end else if (r_count == '0) begin
                            r_state <= S_RESOLVE;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (scan_stop) begin
                        r_pos   <= r_idx;
                        r_cur   <= r_rd_data;
                        r_state <= S_RESOLVE;
                    end else begin
                        r_prev <= r_rd_data;
                        r_idx  <= CNT_W'(r_idx + 1'b1);
                        if (CNT_W'(r_idx + 1'b1) == r_count) begin
                            r_pos   <= r_count;
                            r_state <= S_RESOLVE;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_RESOLVE: begin
                    r_state <= S_FIN;
                    case (r_func)
                        FN_INSERT: begin
                            if (hit) begin
                                r_status <= STS_MISS;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                r_status <= STS_FULL;
                            end else if (r_count == r_pos) begin
                                r_state <= S_INS_WR;
                            end else begin
                                r_idx   <= r_count;
                                r_state <= S_SHU_RD;
                            end
                        end
                        FN_EXISTS: begin
                            if (hit) begin
                                r_found <= 1'b1;
                            end else begin
                                r_status <= STS_MISS;
                            end
                        end
                        FN_MIN, FN_MAX: begin
                            r_found <= 1'b1;
                            r_rk    <= (r_func == FN_MIN) ? r_cur : r_prev;
                        end
                        FN_PRED: begin
                            if (r_pos == '0) begin
                                r_status <= STS_MISS;
                            end else begin
                                r_found <= 1'b1;
                                r_rk    <= r_prev;
                            end
                        end
                        FN_SUCC: begin
                            if (!in_range) begin
                                r_status <= STS_MISS;
                            end else begin
                                r_found <= 1'b1;
                                r_rk    <= r_cur;
                            end
                        end
                        default: begin
                            // Removing forms: check, report, then drop.
                            if (((r_func == FN_REMOVE) && !hit) ||
                                ((r_func == FN_RMPRED) && (r_pos == '0)) ||
                                ((r_func == FN_RMSUCC) && !in_range)) begin
                                r_status <= STS_MISS;
                            end else begin
                                r_found <= 1'b1;
                                r_rk    <= ((r_func == FN_RMPRED) ||
                                            (r_func == FN_RMMAX)) ? r_prev : r_cur;
                                if (drop_short) begin
                                    r_count <= CNT_W'(r_count - 1'b1);
                                end else begin
                                    r_idx   <= drop_q;
                                    r_state <= S_DR_RD;
                                end
                            end
                        end
                    endcase
                end
                S_SHU_RD: begin
                    r_state <= S_SHU_WR;
                end
                S_SHU_WR: begin
                    if (CNT_W'(r_idx - 1'b1) == r_pos) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_idx   <= CNT_W'(r_idx - 1'b1);
                        r_state <= S_SHU_RD;
                    end
                end
                S_INS_WR: begin
                    r_count <= CNT_W'(r_count + 1'b1);
                    r_found <= 1'b1;
                    r_state <= S_FIN;
                end
                S_DR_RD: begin
                    r_state <= S_DR_WR;
                end
                S_DR_WR: begin
                    if (CNT_W'(r_idx + 2'd2) == r_count) begin
                        r_count <= CNT_W'(r_count - 1'b1);
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= CNT_W'(r_idx + 1'b1);
                        r_state <= S_DR_RD;
                    end
                end
                S_FIN: begin
                    o_valid      <= 1'b1;
                    o_status     <= r_status;
                    o_found      <= r_found;
                    o_result_key <= RKEY_W'(r_rk);
                    o_count      <= COUNT_W'(r_count);
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The set never holds more keys than the store has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("key count exceeds capacity");

    // Every memory write lands inside the store.
    a_write_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (mem_addr < CNT_W'(CAPACITY)))
        else $error("memory write outside the store");

    // A result strobe follows only the closing step of a transaction.
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_FIN))
        else $error("result strobe without a finished transaction");

    // An accepted request makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start the sequencer");

    // The key count changes by at most one per cycle, except on clear.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> ((r_count == $past(r_count)) ||
                                 (r_count == CNT_W'($past(r_count) + 1'b1)) ||
                                 (r_count == CNT_W'($past(r_count) - 1'b1))))
        else $error("key count stepped by more than one");
`endif

endmodule
